[src/bhq_pkg.sv]
// Package for the binary min-heap queue: controller state and status codes.
// No dependencies.
package bhq_pkg;

  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    StatOk    = 2'd0,
    StatEmpty = 2'd1,
    StatFull  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StUp,
    StDnLoad,
    StDn,
    StResp
  } state_e;

endpackage

[src/bhq_ram.sv]
// Entry storage for the heap: one write port and two read ports,
// read data registered. No dependencies.
module bhq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[src/binary_min_heap_queue.sv]
// Binary min-heap queue: insert / extract-min over a RAM-backed heap.
// Insert moves the new entry up level by level; extract moves the last entry down from the root.
// One item in flight at a time; each level is one read-compare-write pass through bhq_ram.
// Reset clears the entry count and the controller; the RAM is not cleared.
// Depends on bhq_pkg and bhq_ram.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic [KEY_BITS-1:0]               key_i,
  input  logic [TAG_BITS-1:0]               tag_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [KEY_BITS-1:0]               out_key_o,
  output logic [TAG_BITS-1:0]               out_tag_o,
  output logic [bhq_pkg::StatusW-1:0]       status_o,
  output logic [$clog2(CAPACITY+1)-1:0]     entry_count_o
);
  import bhq_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned ChW  = IdxW + 2;
  localparam int unsigned EntW = KEY_BITS + TAG_BITS;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     pos_q, pos_d;
  logic [EntW-1:0]     ent_q, ent_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;
  logic [TAG_BITS-1:0] res_tag_q, res_tag_d;
  status_e             res_stat_q, res_stat_d;

  logic                out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0] out_key_q;
  logic [TAG_BITS-1:0] out_tag_q;
  status_e             out_stat_q;
  logic [CntW-1:0]     out_count_q;
  logic                out_load;

  logic                we;
  logic [IdxW-1:0]     waddr, raddr_a, raddr_b;
  logic [EntW-1:0]     wdata, rdata_a, rdata_b;

  logic                in_acc;
  logic [ChW-1:0]      left, right, cnt_ext, pick_ch;
  logic                use_right;
  logic [IdxW-1:0]     pick_idx, parent;
  logic [EntW-1:0]     pick_ent;

  bhq_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(EntW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  assign left      = {1'b0, pos_q, 1'b1};
  assign right     = left + ChW'(1);
  assign cnt_ext   = ChW'(count_q);
  assign use_right = (right < cnt_ext) &&
                     (rdata_b[EntW-1:TAG_BITS] < rdata_a[EntW-1:TAG_BITS]);
  assign pick_idx  = use_right ? IdxW'(right) : IdxW'(left);
  assign pick_ent  = use_right ? rdata_b : rdata_a;
  assign pick_ch   = {1'b0, pick_idx, 1'b1};
  assign parent    = IdxW'((pos_q - IdxW'(1)) >> 1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    ent_d      = ent_q;
    res_key_d  = res_key_q;
    res_tag_d  = res_tag_q;
    res_stat_d = res_stat_q;
    we         = 1'b0;
    waddr      = pos_q;
    wdata      = ent_q;
    raddr_a    = '0;
    raddr_b    = '0;
    out_load   = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          res_key_d  = '0;
          res_tag_d  = '0;
          res_stat_d = StatOk;
          if (!command_i) begin
            if (count_q == CntW'(CAPACITY)) begin
              res_stat_d = StatFull;
              state_d    = StResp;
            end else begin
              ent_d   = {key_i, tag_i};
              pos_d   = IdxW'(count_q);
              raddr_a = IdxW'((count_q - CntW'(1)) >> 1);
              count_d = count_q + CntW'(1);
              state_d = StUp;
            end
          end else begin
            if (count_q == '0) begin
              res_stat_d = StatEmpty;
              state_d    = StResp;
            end else begin
              raddr_a = '0;
              raddr_b = IdxW'(count_q - CntW'(1));
              count_d = count_q - CntW'(1);
              state_d = StDnLoad;
            end
          end
        end
      end

      StUp: begin
        // hole walks toward the root; the new entry lands at the root or once the parent is not larger
        we = 1'b1;
        if (pos_q == '0) begin
          state_d = StResp;
        end else if (ent_q[EntW-1:TAG_BITS] < rdata_a[EntW-1:TAG_BITS]) begin
          wdata   = rdata_a;
          pos_d   = parent;
          raddr_a = IdxW'((parent - IdxW'(1)) >> 1);
        end else begin
          state_d = StResp;
        end
      end

      StDnLoad: begin
        res_key_d = rdata_a[EntW-1:TAG_BITS];
        res_tag_d = rdata_a[TAG_BITS-1:0];
        ent_d     = rdata_b;
        pos_d     = '0;
        raddr_a   = IdxW'(1);
        raddr_b   = IdxW'(2);
        state_d   = StDn;
      end

      StDn: begin
        we = 1'b1;
        if (left >= cnt_ext) begin
          state_d = StResp;
        end else if (pick_ent[EntW-1:TAG_BITS] <= ent_q[EntW-1:TAG_BITS]) begin
          wdata   = pick_ent;
          pos_d   = pick_idx;
          raddr_a = IdxW'(pick_ch);
          raddr_b = IdxW'(pick_ch + ChW'(1));
        end else begin
          state_d = StResp;
        end
      end

      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    ent_q      <= ent_d;
    res_key_q  <= res_key_d;
    res_tag_q  <= res_tag_d;
    res_stat_q <= res_stat_d;
    if (out_load) begin
      out_key_q   <= res_key_q;
      out_tag_q   <= res_tag_q;
      out_stat_q  <= res_stat_q;
      out_count_q <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_key_o     = out_key_q;
  assign out_tag_o     = out_tag_q;
  assign status_o      = out_stat_q;
  assign entry_count_o = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q))
    else $error("entry count changed without an accepted item");

  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !command_i && count_q == CntW'(CAPACITY)) |=>
      (state_q == StResp && res_stat_q == StatFull))
    else $error("insert into full heap not refused");

endmodule
